// File: hw/rtl/cma_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cma_pkg
// Shared widths, stage data type and arctangent table for the rectangular to
// polar converter.
// ----------------------------------------------------------------------------
package cma_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int ITERATIONS = 16;

  // one pipeline stage per CORDIC iteration or per root bit, whichever is more
  localparam int NSTG = (ITERATIONS > DATA_WIDTH) ? ITERATIONS : DATA_WIDTH;
  localparam int IW   = $clog2(NSTG);

  localparam int XW   = DATA_WIDTH + 3;   // rotated vector, CORDIC gain headroom
  localparam int ZW   = 34;               // angle accumulator, units of pi/2^31
  localparam int SW   = 2 * DATA_WIDTH;   // sum of squares and root remainder
  localparam int TW   = SW + 2;           // root trial value
  localparam int DROP = 32 - DATA_WIDTH;  // accumulator bits below the output lsb

  localparam logic signed [ZW-1:0] Z_PI   = ZW'(64'sd1 <<< 31);
  localparam logic signed [ZW-1:0] Z_HALF = (ZW'(64'sd1) <<< DROP) >>> 1;
  localparam logic signed [ZW-1:0] Z_MAX  = ZW'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
  localparam logic signed [ZW-1:0] Z_MIN  = -Z_MAX - ZW'(64'sd1);

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [SW-1:0]        rem;    // sum of squares less root squared
    logic [DATA_WIDTH-1:0] root;
    logic                 im_zero;
    logic                 re_neg;
  } cma_data_t;

  // round(atan(2^-i) * 2^31 / pi)
  function automatic logic [31:0] atan_val(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      5'd24:   v = 32'd41;
      5'd25:   v = 32'd20;
      5'd26:   v = 32'd10;
      5'd27:   v = 32'd5;
      5'd28:   v = 32'd3;
      5'd29:   v = 32'd1;
      5'd30:   v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/cma_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cma_stage
// One pipeline stage: a vectoring CORDIC micro-rotation alongside one bit of
// the digit-by-digit square root. Either half passes through when its count
// of steps is used up.
// ----------------------------------------------------------------------------
module cma_stage
  import cma_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [IW-1:0]   stage_idx,
  input  wire logic            in_vld,
  input  wire cma_data_t       in_d,
  output logic                 out_vld,
  output cma_data_t            out_d
);

  logic                  vld_r;
  cma_data_t             d_r;
  cma_data_t             d_nxt;
  logic                  do_rot;
  logic                  do_root;
  logic signed [XW-1:0]  xs;
  logic signed [XW-1:0]  ys;
  logic signed [ZW-1:0]  at;
  logic [IW-1:0]         bpos;
  logic [TW-1:0]         trial;
  logic [TW-1:0]         rem_ext;

  assign do_rot  = {1'b0, stage_idx} < (IW+1)'(ITERATIONS);
  assign do_root = {1'b0, stage_idx} < (IW+1)'(DATA_WIDTH);
  assign bpos    = IW'(DATA_WIDTH - 1) - stage_idx;

  assign xs = in_d.x >>> stage_idx;
  assign ys = in_d.y >>> stage_idx;
  assign at = $signed(ZW'(atan_val(5'(stage_idx))));

  // (root + 2^b)^2 - root^2 = root * 2^(b+1) + 2^(2b)
  assign trial   = ((TW'(in_d.root) << bpos) << 1) + (TW'(1) << {bpos, 1'b0});
  assign rem_ext = TW'(in_d.rem);

  always_comb begin
    d_nxt = in_d;
    if (do_rot) begin
      if (!in_d.y[XW-1]) begin
        d_nxt.x = in_d.x + ys;
        d_nxt.y = in_d.y - xs;
        d_nxt.z = in_d.z + at;
      end else begin
        d_nxt.x = in_d.x - ys;
        d_nxt.y = in_d.y + xs;
        d_nxt.z = in_d.z - at;
      end
    end
    if (do_root && (rem_ext >= trial)) begin
      d_nxt.rem  = SW'(rem_ext - trial);
      d_nxt.root = in_d.root | (DATA_WIDTH'(1) << bpos);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

  assign out_vld = vld_r;
  assign out_d   = d_r;

endmodule
`default_nettype wire

// File: hw/rtl/complex_magnitude_angle_top.sv
`default_nettype none
// Between a taken request and its out_valid strobe lie one input stage, one
// stage per CORDIC step or root bit, and one output stage, all registered.
// Throughput: one request per cycle, set by the fully unrolled stage chain;
// busy is low at all times after reset.
// Reset: synchronous, active low; clears all valid bits and holds busy high
// while asserted. Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
// complex_magnitude_angle_top
// Rectangular to polar conversion: rounded magnitude by an exact integer
// square root and four-quadrant angle by a vectoring CORDIC.
// ----------------------------------------------------------------------------
module complex_magnitude_angle_top
  import cma_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [DATA_WIDTH-1:0] in_real_part,
  input  wire logic signed [DATA_WIDTH-1:0] in_imag_part,
  output logic                              out_valid,
  output logic [DATA_WIDTH-1:0]             out_magnitude,
  output logic signed [DATA_WIDTH-1:0]      out_angle
);

  logic                          busy_r;
  logic                          in_accept;
  logic signed [SW-1:0]          sq_re;
  logic signed [SW-1:0]          sq_im;
  logic signed [XW-1:0]          re_x;
  logic signed [XW-1:0]          im_x;
  cma_data_t                     in_nxt;
  logic                          vld_q [0:NSTG];
  cma_data_t                     d_q   [0:NSTG];
  cma_data_t                     last_d;
  logic [DATA_WIDTH:0]           mag_inc;
  logic signed [ZW-1:0]          z_rnd;
  logic signed [ZW-1:0]          z_sat;
  logic [DATA_WIDTH-1:0]         mag_nxt;
  logic signed [DATA_WIDTH-1:0]  ang_nxt;
  logic                          out_valid_r;
  logic [DATA_WIDTH-1:0]         out_magnitude_r;
  logic signed [DATA_WIDTH-1:0]  out_angle_r;
  logic                          a_vld_r;
  cma_data_t                     a_d_r;

  assign in_accept = start && !busy_r;

  // input stage: squares for the root, pre-rotation into the right half plane
  assign sq_re = in_real_part * in_real_part;
  assign sq_im = in_imag_part * in_imag_part;
  assign re_x  = XW'(in_real_part);
  assign im_x  = XW'(in_imag_part);

  always_comb begin
    in_nxt.rem     = $unsigned(sq_re) + $unsigned(sq_im);
    in_nxt.root    = '0;
    in_nxt.im_zero = (in_imag_part == '0);
    in_nxt.re_neg  = in_real_part[DATA_WIDTH-1];
    if (in_real_part[DATA_WIDTH-1]) begin
      in_nxt.x = -re_x;
      in_nxt.y = -im_x;
      in_nxt.z = in_imag_part[DATA_WIDTH-1] ? -Z_PI : Z_PI;
    end else begin
      in_nxt.x = re_x;
      in_nxt.y = im_x;
      in_nxt.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b1;
      a_vld_r <= 1'b0;
    end else begin
      busy_r  <= 1'b0;
      a_vld_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    a_d_r <= in_nxt;
  end

  assign vld_q[0] = a_vld_r;
  assign d_q[0]   = a_d_r;

  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    cma_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_idx (IW'(k)),
      .in_vld    (vld_q[k]),
      .in_d      (d_q[k]),
      .out_vld   (vld_q[k+1]),
      .out_d     (d_q[k+1])
    );
  end

  // output stage: round the root to nearest, round and clamp the angle
  assign last_d  = d_q[NSTG];
  assign mag_inc = {1'b0, last_d.root} + (DATA_WIDTH+1)'(1);
  assign z_rnd   = (last_d.z + Z_HALF) >>> DROP;

  always_comb begin
    if (last_d.rem > SW'(last_d.root)) begin
      mag_nxt = mag_inc[DATA_WIDTH-1:0];
    end else begin
      mag_nxt = last_d.root;
    end
    if (z_rnd > Z_MAX) begin
      z_sat = Z_MAX;
    end else if (z_rnd < Z_MIN) begin
      z_sat = Z_MIN;
    end else begin
      z_sat = z_rnd;
    end
    if (last_d.im_zero) begin
      ang_nxt = last_d.re_neg ? DATA_WIDTH'(Z_MAX) : '0;
    end else begin
      ang_nxt = DATA_WIDTH'(z_sat);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_q[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    out_magnitude_r <= mag_nxt;
    out_angle_r     <= ang_nxt;
  end

  assign busy          = busy_r;
  assign out_valid     = out_valid_r;
  assign out_magnitude = out_magnitude_r;
  assign out_angle     = out_angle_r;

  localparam int LAT = NSTG + 2;

  ast_req_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> ##LAT out_valid)
    else $error("request did not produce a result strobe");

  ast_result_has_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_accept, LAT))
    else $error("result strobe without a matching request");

  ast_zero_vector_angle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_magnitude == '0)) |-> (out_angle == '0))
    else $error("zero vector gave a non-zero angle");

  ast_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy raised outside reset");

endmodule
`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the rectangular to polar converter. Complex samples are queued by
// the stimulus process, a clocked driver presents them as start requests
// with random gaps, and a clocked monitor predicts the rounded magnitude and
// CORDIC angle of each accepted request. It then matches every out_valid
// strobe against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module testbench
  import cma_pkg::*;
();

  localparam int PIPE_DEPTH  = NSTG + 1;
  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_ITEMS = 650;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] re;
    logic signed [DATA_WIDTH-1:0] im;
  } sample_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0]        magnitude;
    logic signed [DATA_WIDTH-1:0] angle;
  } polar_t;

  logic                         clk;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  logic signed [DATA_WIDTH-1:0] in_real_part;
  logic signed [DATA_WIDTH-1:0] in_imag_part;
  logic                         out_valid;
  logic [DATA_WIDTH-1:0]        out_magnitude;
  logic signed [DATA_WIDTH-1:0] out_angle;

  sample_t sample_queue[$];
  polar_t  polar_pending[$];

  logic    req_taken;
  int      stall_cycles;
  int      accepted_count;
  int      issued_count;
  int      error_count;
  int      total_items;
  bit      timed_out;
  sample_t next_sample;
  polar_t  seen_polar;

  // arctangent of 2^-i in units of pi/2^31
  longint atan_step [0:31] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0
  };

  complex_magnitude_angle_top u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_real_part  (in_real_part),
    .in_imag_part  (in_imag_part),
    .out_valid     (out_valid),
    .out_magnitude (out_magnitude),
    .out_angle     (out_angle)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic polar_t polar_of(input logic signed [DATA_WIDTH-1:0] re_in,
                                      input logic signed [DATA_WIDTH-1:0] im_in);
    longint re, im, ar, ai, sq, rest, root, bitv;
    longint x, y, z, xs, ys, zmax, zmin;
    polar_t res;
    re = re_in;
    im = im_in;
    ar = (re < 0) ? -re : re;
    ai = (im < 0) ? -im : im;
    sq = ar * ar + ai * ai;

    // exact integer square root, then round to nearest
    rest = sq;
    root = 0;
    bitv = 64'sd1 <<< 62;
    while (bitv > rest) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (rest >= root + bitv) begin
        rest = rest - (root + bitv);
        root = (root >>> 1) + bitv;
      end else begin
        root = root >>> 1;
      end
      bitv = bitv >>> 2;
    end
    if (sq - root * root > root) root = root + 1;
    res.magnitude = DATA_WIDTH'(root);

    zmax = (64'sd1 <<< (DATA_WIDTH - 1)) - 1;
    zmin = -(64'sd1 <<< (DATA_WIDTH - 1));
    if (im == 0) begin
      z = (re >= 0) ? 0 : zmax;
    end else begin
      x = re;
      y = im;
      z = 0;
      // fold the left half plane onto the right one
      if (x < 0) begin
        x = -x;
        y = -y;
        z = (im >= 0) ? (64'sd1 <<< 31) : -(64'sd1 <<< 31);
      end
      for (int i = 0; i < ITERATIONS && i < 32; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + atan_step[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - atan_step[i];
        end
      end
      if (DROP > 0) z = (z + (64'sd1 <<< (DROP - 1))) >>> DROP;
      if (z > zmax) z = zmax;
      if (z < zmin) z = zmin;
    end
    res.angle = DATA_WIDTH'(z);
    return res;
  endfunction

  task automatic queue_sample(input int re, input int im);
    sample_t s;
    s.re = DATA_WIDTH'(re);
    s.im = DATA_WIDTH'(im);
    sample_queue.push_back(s);
  endtask

  // driver: advance to the next request once the current one is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || req_taken) begin
      if (sample_queue.size() != 0 &&
          !((issued_count < 250 || issued_count >= 420) && $urandom_range(99) < 25)) begin
        next_sample = sample_queue.pop_front();
        in_real_part <= next_sample.re;
        in_imag_part <= next_sample.im;
        start        <= 1'b1;
        issued_count = issued_count + 1;
      end else begin
        // scramble the idle bus so that stale data is never taken
        in_real_part <= DATA_WIDTH'($urandom);
        in_imag_part <= DATA_WIDTH'($urandom);
        start        <= 1'b0;
      end
    end
  end

  // monitor: check strobed results, then predict for a newly taken request
  always @(posedge clk) begin
    if (!rst_n) begin
      req_taken    <= 1'b0;
      stall_cycles <= 0;
    end else begin
      if (out_valid) begin
        if (polar_pending.size() == 0) begin
          error_count = error_count + 1;
          $display("%0t: result with no request outstanding: magnitude %0d angle %0d",
                   $time, out_magnitude, out_angle);
        end else begin
          seen_polar = polar_pending.pop_front();
          if (out_magnitude !== seen_polar.magnitude) begin
            error_count = error_count + 1;
            $display("%0t: magnitude mismatch: expected %0d, actual %0d",
                     $time, seen_polar.magnitude, out_magnitude);
          end
          if (out_angle !== seen_polar.angle) begin
            error_count = error_count + 1;
            $display("%0t: angle mismatch: expected %0d, actual %0d",
                     $time, seen_polar.angle, out_angle);
          end
        end
      end
      if (start && !busy) begin
        polar_pending.push_back(polar_of(in_real_part, in_imag_part));
        accepted_count = accepted_count + 1;
      end
      req_taken    <= start && !busy;
      stall_cycles <= ((start && !busy) || out_valid) ? 0 : stall_cycles + 1;
    end
  end

  initial begin
    int pick;
    int mag_a;
    int mag_b;
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_real_part   <= '0;
    in_imag_part   <= '0;
    accepted_count = 0;
    issued_count   = 0;
    error_count    = 0;
    timed_out      = 1'b0;

    // corners, axes and the angles either side of +pi
    queue_sample(0, 0);
    queue_sample(32767, 0);
    queue_sample(-32768, 0);
    queue_sample(-1, 0);
    queue_sample(1, 0);
    queue_sample(0, 32767);
    queue_sample(0, -32768);
    queue_sample(0, 1);
    queue_sample(0, -1);
    queue_sample(32767, 32767);
    queue_sample(-32768, -32768);
    queue_sample(-32768, 32767);
    queue_sample(32767, -32768);
    queue_sample(-32768, 1);
    queue_sample(-32768, -1);
    queue_sample(-32767, 1);
    queue_sample(1, 1);
    queue_sample(-1, 1);
    queue_sample(-1, -1);
    queue_sample(1, -1);
    queue_sample(3, 4);
    queue_sample(-30000, 20000);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(9);
      case (pick)
        5: begin
          queue_sample(int'($urandom_range(32)) - 16, int'($urandom_range(32)) - 16);
        end
        6: begin
          if ($urandom_range(1) == 0) queue_sample($signed(16'($urandom)), 0);
          else                        queue_sample(0, $signed(16'($urandom)));
        end
        7: begin
          case ($urandom_range(5))
            0:       mag_a = -32768;
            1:       mag_a = -32767;
            2:       mag_a = -1;
            3:       mag_a = 0;
            4:       mag_a = 1;
            default: mag_a = 32767;
          endcase
          case ($urandom_range(5))
            0:       mag_b = -32768;
            1:       mag_b = -32767;
            2:       mag_b = -1;
            3:       mag_b = 0;
            4:       mag_b = 1;
            default: mag_b = 32767;
          endcase
          queue_sample(mag_a, mag_b);
        end
        8: begin
          mag_a = $signed(16'($urandom));
          mag_b = int'($urandom_range(8)) - 4;
          if ($urandom_range(1) == 0) queue_sample(mag_a, mag_b);
          else                        queue_sample(mag_b, mag_a);
        end
        9: begin
          mag_a = $signed(16'($urandom));
          queue_sample(mag_a, ($urandom_range(1) == 0) ? mag_a : -mag_a);
        end
        default: begin
          queue_sample($signed(16'($urandom)), $signed(16'($urandom)));
        end
      endcase
    end
    total_items = sample_queue.size();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // hold until every request is taken and every result has come back
    while (!(accepted_count == total_items && polar_pending.size() == 0) &&
           stall_cycles < STALL_LIMIT)
      @(negedge clk);
    if (stall_cycles >= STALL_LIMIT) timed_out = 1'b1;
    if (!timed_out) repeat (PIPE_DEPTH + 8) @(posedge clk);

    if (!timed_out && error_count == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule
